// ----- hdl/mhtq_pkg.sv -----
// shared types, codes and the ordering compare for the timer heap
// no dependencies
package mhtq_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TIME_BITS  = 32;
  localparam int ID_W       = 6;
  localparam int PAY_W      = 32;
  localparam int ORD_W      = 64;
  localparam int MAX_RES    = 64;
  localparam int RES_AW     = $clog2(MAX_RES);
  localparam int RES_CW     = RES_AW + 1;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_POP    = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_EXPIRED = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  // one heap slot
  typedef struct packed {
    logic [TIME_BITS-1:0] tm;
    logic [ID_W-1:0]      id;
    logic [ORD_W-1:0]     ord;
    logic [PAY_W-1:0]     pay;
  } heap_ent_t;

  // one buffered result word
  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] pay;
  } res_ent_t;

  localparam int HEAP_W = $bits(heap_ent_t);
  localparam int RES_W  = $bits(res_ent_t);

  // true if a must sit above b: earlier expiry, then earlier insertion
  function automatic logic ent_before(heap_ent_t a, heap_ent_t b);
    logic r;
    if (a.tm != b.tm) r = (a.tm < b.tm);
    else              r = (a.ord < b.ord);
    return r;
  endfunction

endpackage

// ----- hdl/mhtq_ram.sv -----
// generic single write, single read memory with registered read data
// no dependencies
module mhtq_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/min_heap_timer_queue_top.sv -----
// timer heap top level: sequencer, shared compare, heap and result memories
// depends on mhtq_pkg and mhtq_ram
//
// Usage. One input channel (in_valid_i / in_stall_o) takes request words:
// add, cancel, tick or pop. One output channel (out_valid_o / out_stall_i)
// gives result words; the final word of a request carries last_o.
// A request is taken only when the block is idle; in_stall_o stays high
// from acceptance until the last result word has been loaded into the
// output register, so the next request may enter while that word waits.
// An add climbs the heap level by level, a pop descends it level by level
// and a tick removes one expired head after another. The heap memory has
// a single read port: one slot is read per cycle and every compare goes
// through one shared comparator.
// Results of every request are gathered in a result memory first, as
// each word reports head and count as they stand after the whole request.
// Reset clears the count, the cancel flags and all control state; heap
// contents need no clearing. A stalled output word holds its value.
module min_heap_timer_queue_top
  import mhtq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [ID_W-1:0]      timer_id_i,
  input  logic [31:0]          expire_time_i,
  input  logic [31:0]          payload_i,
  input  logic [31:0]          now_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [ID_W-1:0]      out_id_o,
  output logic [31:0]          out_payload_o,
  output logic                 head_valid_o,
  output logic [31:0]          head_expire_o,
  output logic [6:0]           entry_count_o,
  output logic                 last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CHK, S_UP_CMP, S_POP_HD, S_RM_LAST, S_RM_CHK, S_RM_C1,
    S_RM_C2, S_RM_CMP, S_DONE, S_TK_CHK, S_TK_HD, S_HEAD, S_HEAD_RD,
    S_EM_RD, S_EM_LD
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     hole_q, hole_d;
  logic [CNT_W-1:0]     bidx_q, bidx_d;
  heap_ent_t            k_q, k_d;
  heap_ent_t            best_q, best_d;
  logic [ORD_W-1:0]     ord_q, ord_d;
  logic [1:0]           req_q, req_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [ID_W-1:0]      hid_q, hid_d;
  logic [PAY_W-1:0]     hpay_q, hpay_d;
  logic [RES_CW-1:0]    n_q, n_d;
  logic [RES_CW-1:0]    wr_q, wr_d;
  logic [RES_CW-1:0]    rd_q, rd_d;
  logic [TIME_BITS-1:0] htime_q, htime_d;
  logic [63:0]          cancel_q, cancel_d;

  logic                 ov_q, ov_d;
  res_ent_t             ores_q, ores_d;
  logic                 ohv_q, ohv_d;
  logic [31:0]          oht_q, oht_d;
  logic [6:0]           ocnt_q, ocnt_d;
  logic                 olast_q, olast_d;

  // heap memory port signals
  logic                 hm_we, hm_re;
  logic [IDX_W-1:0]     hm_waddr, hm_raddr;
  heap_ent_t            hm_wdata, hm_rdata;

  // result memory port signals
  logic                 rb_we, rb_re;
  res_ent_t             rb_wdata, rb_rdata;

  // shared compare unit
  heap_ent_t            cmp_a, cmp_b;
  logic                 cmp_lt;

  logic [CNT_W-1:0]     child;
  logic                 load_out;

  mhtq_ram #(.W(HEAP_W), .D(HEAP_DEPTH)) u_heap (
    .clk_i   (clk_i),
    .we_i    (hm_we),
    .waddr_i (hm_waddr),
    .wdata_i (hm_wdata),
    .re_i    (hm_re),
    .raddr_i (hm_raddr),
    .rdata_o (hm_rdata)
  );

  mhtq_ram #(.W(RES_W), .D(MAX_RES)) u_res (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (wr_q[RES_AW-1:0]),
    .wdata_i (rb_wdata),
    .re_i    (rb_re),
    .raddr_i (rd_q[RES_AW-1:0]),
    .rdata_o (rb_rdata)
  );

  // operand select for the comparator
  always_comb begin
    cmp_a = best_q;
    cmp_b = k_q;
    unique case (state_q)
      S_UP_CMP: begin cmp_a = k_q;      cmp_b = hm_rdata; end
      S_RM_C2:  begin cmp_a = hm_rdata; cmp_b = best_q;   end
      default:  begin cmp_a = best_q;   cmp_b = k_q;      end
    endcase
  end

  assign cmp_lt   = ent_before(cmp_a, cmp_b);
  assign child    = {hole_q[CNT_W-2:0], 1'b1};
  assign load_out = !ov_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    hole_d   = hole_q;
    bidx_d   = bidx_q;
    k_d      = k_q;
    best_d   = best_q;
    ord_d    = ord_q;
    req_d    = req_q;
    now_d    = now_q;
    hid_d    = hid_q;
    hpay_d   = hpay_q;
    n_d      = n_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    htime_d  = htime_q;
    cancel_d = cancel_q;
    ov_d     = ov_q && out_stall_i;
    ores_d   = ores_q;
    ohv_d    = ohv_q;
    oht_d    = oht_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    hm_we    = 1'b0;
    hm_waddr = hole_q[IDX_W-1:0];
    hm_wdata = k_q;
    hm_re    = 1'b0;
    hm_raddr = '0;
    rb_we    = 1'b0;
    rb_wdata = '{status: ST_OK, id: '0, pay: '0};
    rb_re    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_type_i;
          now_d = now_i;
          n_d   = '0;
          unique case (req_type_i)
            REQ_ADD: begin
              if (count_q == CNT_W'(HEAP_DEPTH)) begin
                rb_we    = 1'b1;
                rb_wdata = '{status: ST_FULL, id: '0, pay: '0};
                wr_d     = wr_q + 1'b1;
                state_d  = S_HEAD;
              end else begin
                k_d = '{tm: expire_time_i, id: timer_id_i, ord: ord_q, pay: payload_i};
                ord_d   = ord_q + 1'b1;
                hole_d  = count_q;
                count_d = count_q + 1'b1;
                cancel_d[timer_id_i] = 1'b0;
                state_d = S_UP_CHK;
              end
            end
            REQ_CANCEL: begin
              cancel_d[timer_id_i] = 1'b1;
              rb_we    = 1'b1;
              wr_d     = wr_q + 1'b1;
              state_d  = S_HEAD;
            end
            REQ_POP: begin
              if (count_q == '0) begin
                rb_we    = 1'b1;
                rb_wdata = '{status: ST_EMPTY, id: '0, pay: '0};
                wr_d     = wr_q + 1'b1;
                state_d  = S_HEAD;
              end else begin
                hm_re    = 1'b1;
                state_d  = S_POP_HD;
              end
            end
            default: state_d = S_TK_CHK;
          endcase
        end
      end

      // sift up: read the parent, then move it down or settle
      S_UP_CHK: begin
        if (hole_q == '0) begin
          hm_we    = 1'b1;
          rb_we    = 1'b1;
          wr_d     = wr_q + 1'b1;
          state_d  = S_HEAD;
        end else begin
          hm_re    = 1'b1;
          hm_raddr = IDX_W'((hole_q - 1'b1) >> 1);
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        hm_we = 1'b1;
        if (cmp_lt) begin
          hm_wdata = hm_rdata;
          hole_d   = (hole_q - 1'b1) >> 1;
          state_d  = S_UP_CHK;
        end else begin
          rb_we    = 1'b1;
          wr_d     = wr_q + 1'b1;
          state_d  = S_HEAD;
        end
      end

      // head read for a pop, then fetch the last slot (a tick removal also lands there)
      S_POP_HD: begin
        hid_d   = hm_rdata.id;
        hpay_d  = hm_rdata.pay;
        count_d = count_q - 1'b1;
        if (count_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end else begin
          hm_re    = 1'b1;
          hm_raddr = IDX_W'(count_q - 1'b1);
          state_d  = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        k_d     = hm_rdata;
        hole_d  = '0;
        state_d = S_RM_CHK;
      end

      // sift down: read one or two children, pick the earlier, compare
      S_RM_CHK: begin
        if (child >= count_q) begin
          hm_we   = 1'b1;
          state_d = S_DONE;
        end else begin
          hm_re    = 1'b1;
          hm_raddr = child[IDX_W-1:0];
          bidx_d   = child;
          state_d  = S_RM_C1;
        end
      end
      S_RM_C1: begin
        best_d = hm_rdata;
        if (bidx_q + 1'b1 < count_q) begin
          hm_re    = 1'b1;
          hm_raddr = IDX_W'(bidx_q + 1'b1);
          state_d  = S_RM_C2;
        end else begin
          state_d  = S_RM_CMP;
        end
      end
      S_RM_C2: begin
        if (cmp_lt) begin
          best_d = hm_rdata;
          bidx_d = bidx_q + 1'b1;
        end
        state_d = S_RM_CMP;
      end
      S_RM_CMP: begin
        hm_we = 1'b1;
        if (cmp_lt) begin
          hm_wdata = best_q;
          hole_d   = bidx_q;
          state_d  = S_RM_CHK;
        end else begin
          state_d  = S_DONE;
        end
      end

      // removal finished: report it, unless a tick removed a cancelled timer
      S_DONE: begin
        if (req_q == REQ_POP) begin
          rb_we    = 1'b1;
          rb_wdata = '{status: ST_OK, id: hid_q, pay: hpay_q};
          wr_d     = wr_q + 1'b1;
          state_d  = S_HEAD;
        end else begin
          if (!cancel_q[hid_q]) begin
            rb_we    = 1'b1;
            rb_wdata = '{status: ST_EXPIRED, id: hid_q, pay: hpay_q};
            wr_d     = wr_q + 1'b1;
            n_d      = n_q + 1'b1;
          end
          state_d = S_TK_CHK;
        end
      end

      // tick: look at the head while room remains
      S_TK_CHK: begin
        if (count_q == '0 || n_q == RES_CW'(MAX_RES)) begin
          state_d = S_HEAD;
        end else begin
          hm_re   = 1'b1;
          state_d = S_TK_HD;
        end
      end
      S_TK_HD: begin
        if (hm_rdata.tm <= now_q) begin
          hid_d   = hm_rdata.id;
          hpay_d  = hm_rdata.pay;
          count_d = count_q - 1'b1;
          if (count_q == CNT_W'(1)) begin
            state_d = S_DONE;
          end else begin
            hm_re    = 1'b1;
            hm_raddr = IDX_W'(count_q - 1'b1);
            state_d  = S_RM_LAST;
          end
        end else begin
          state_d = S_HEAD;
        end
      end

      // final head read, plus a none word for a tick that expired nothing
      S_HEAD: begin
        if (req_q == REQ_TICK && n_q == '0) begin
          rb_we    = 1'b1;
          rb_wdata = '{status: ST_NONE, id: '0, pay: '0};
          wr_d     = wr_q + 1'b1;
        end
        hm_re   = 1'b1;
        state_d = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        htime_d = (count_q == '0) ? '0 : hm_rdata.tm;
        rd_d    = '0;
        state_d = S_EM_RD;
      end

      // drain the result memory into the output register
      S_EM_RD: begin
        rb_re   = 1'b1;
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        if (load_out) begin
          ov_d    = 1'b1;
          ores_d  = rb_rdata;
          ohv_d   = (count_q != '0);
          oht_d   = htime_q;
          ocnt_d  = 7'(count_q);
          olast_d = (rd_q + 1'b1 == wr_q);
          rd_d    = rd_q + 1'b1;
          if (rd_q + 1'b1 == wr_q) begin
            wr_d    = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_EM_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state, counters and the output valid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ord_q    <= '0;
      n_q      <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      cancel_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ord_q    <= ord_d;
      n_q      <= n_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      cancel_q <= cancel_d;
      ov_q     <= ov_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    hole_q  <= hole_d;
    bidx_q  <= bidx_d;
    k_q     <= k_d;
    best_q  <= best_d;
    req_q   <= req_d;
    now_q   <= now_d;
    hid_q   <= hid_d;
    hpay_q  <= hpay_d;
    htime_q <= htime_d;
    ores_q  <= ores_d;
    ohv_q   <= ohv_d;
    oht_q   <= oht_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = ov_q;
  assign status_o      = ores_q.status;
  assign out_id_o      = ores_q.id;
  assign out_payload_o = ores_q.pay;
  assign head_valid_o  = ohv_q;
  assign head_expire_o = oht_q;
  assign entry_count_o = ocnt_q;
  assign last_o        = olast_q;

  // heap never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(HEAP_DEPTH))
    else $error("heap count above capacity");

  // heap writes stay inside the live region
  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hm_we |-> (CNT_W'(hm_waddr) < count_q))
    else $error("heap write beyond live entries");

  // drain pointer never passes the fill pointer
  a_drain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EM_RD || state_q == S_EM_LD) |-> (rd_q < wr_q))
    else $error("result drain past fill");

  // loading the final word returns to idle with an empty result memory
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EM_LD && load_out && rd_q + 1'b1 == wr_q)
      |=> (state_q == S_IDLE && wr_q == '0 && out_valid_o && last_o))
    else $error("final word did not close the request");

endmodule
